// File: rtl/core/scba_pkg.sv
package scba_pkg;

    localparam int CHUNK_BYTES   = 65536;
    localparam int NUM_CHUNKS    = 8;
    localparam int NUM_CLASSES   = 60;
    localparam int GRANULE_BYTES = 16;

    localparam int GRAN_SHIFT    = $clog2(GRANULE_BYTES);
    localparam int CHUNK_GRANS   = CHUNK_BYTES / GRANULE_BYTES;
    localparam int POOL_GRANS    = NUM_CHUNKS * CHUNK_GRANS;
    localparam int GW            = $clog2(POOL_GRANS);
    localparam int CW            = $clog2(NUM_CLASSES + 1);
    localparam int CGW           = $clog2(CHUNK_GRANS);
    localparam int NCW           = $clog2(NUM_CHUNKS + 1);
    localparam int FIFO_DEPTH    = 2;

    localparam logic [1:0] ACT_ALLOC = 2'd0;
    localparam logic [1:0] ACT_FREE  = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_ZERO  = 2'd1;
    localparam logic [1:0] ST_LARGE = 2'd2;
    localparam logic [1:0] ST_OUT   = 2'd3;

    localparam logic [2:0] OP_NOP   = 3'd0;
    localparam logic [2:0] OP_ALLOC = 3'd1;
    localparam logic [2:0] OP_FREE  = 3'd2;
    localparam logic [2:0] OP_CLEAR = 3'd3;

    typedef struct packed {
        logic [2:0]    op;
        logic [1:0]    status;
        logic [5:0]    cls;
        logic          in_pool;
        logic [GW-1:0] gran;
    } cmd_t;

    function automatic logic [15:0] class_units(input logic [5:0] c);
        logic [15:0] t [0:59];
        t = '{16'd1, 16'd2, 16'd4, 16'd6, 16'd8, 16'd10, 16'd12, 16'd14, 16'd16,
              16'd20, 16'd24, 16'd28, 16'd32, 16'd40, 16'd48, 16'd56, 16'd64,
              16'd80, 16'd96, 16'd112, 16'd128, 16'd144, 16'd160, 16'd176,
              16'd192, 16'd208, 16'd224, 16'd240, 16'd256, 16'd288, 16'd320,
              16'd352, 16'd384, 16'd416, 16'd448, 16'd480, 16'd512, 16'd576,
              16'd640, 16'd704, 16'd768, 16'd832, 16'd896, 16'd960, 16'd1024,
              16'd1152, 16'd1280, 16'd1408, 16'd1536, 16'd1664, 16'd1792,
              16'd1920, 16'd2048, 16'd2304, 16'd2560, 16'd2816, 16'd3072,
              16'd3328, 16'd3584, 16'd3840};
        if (c < 6'd60)
            class_units = t[c];
        else
            class_units = 16'd0;
    endfunction

endpackage

// File: rtl/core/size_class_block_allocator_top.sv
// A result is registered through the front hold register, the request queue and
// the back end's head state; a list pop gives its result from the read state instead.
// The back end carries out one request at a time: a list pop also reads the link
// table, and an allocation that carves a chunk walks it one block a cycle (up to
// 4096 blocks) before the next request is carried out.
// Reset: asynchronous, active low; all lists empty, no chunks used, limit 8.
// The receiver cannot stall: done is a one-cycle strobe.
module size_class_block_allocator_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  action,
    input  logic [23:0] request_size,
    input  logic [18:0] block_address,
    input  logic        chunk_limit_we,
    input  logic [3:0]  chunk_limit,
    output logic        done,
    output logic [18:0] result_address,
    output logic [1:0]  status,
    output logic [5:0]  size_class
);
    import scba_pkg::*;

    logic q_full, q_push, q_pop, q_ne;
    cmd_t push_cmd, head_cmd;

    scba_front u_front (
        .clk(clk), .rst_n(rst_n), .start(start), .action(action),
        .request_size(request_size), .block_address(block_address),
        .q_full(q_full), .busy(busy), .push(q_push), .push_cmd(push_cmd)
    );

    scba_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(q_push), .push_cmd(push_cmd),
        .pop(q_pop), .full(q_full), .not_empty(q_ne), .head_cmd(head_cmd)
    );

    scba_back u_back (
        .clk(clk), .rst_n(rst_n), .cfg_we(chunk_limit_we), .cfg_data(chunk_limit),
        .q_valid(q_ne), .q_cmd(head_cmd), .q_pop(q_pop),
        .done(done), .result_address(result_address), .status(status),
        .size_class(size_class)
    );
endmodule

// File: rtl/core/scba_front.sv
module scba_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [1:0]           action,
    input  logic [23:0]          request_size,
    input  logic [18:0]          block_address,
    input  logic                 q_full,
    output logic                 busy,
    output logic                 push,
    output scba_pkg::cmd_t       push_cmd
);
    import scba_pkg::*;

    // Item held until the queue takes it, while the class search runs over a registered size.
    logic        hold_reg, hold_next;
    logic [1:0]  act_reg;
    logic [23:0] size_reg;
    logic [18:0] addr_reg;
    logic [CW-1:0] cls;
    logic        found;

    assign busy = hold_reg;

    always_comb
    begin
        cls = CW'(NUM_CLASSES);
        found = 1'b0;
        for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
            if ({4'd0, size_reg} <= 28'(class_units(6'(c))) * 28'(GRANULE_BYTES)) begin
                cls = CW'(c);
                found = 1'b1;
            end
        end
    end

    always_comb
    begin
        push_cmd = '0;
        push_cmd.gran = GW'(addr_reg >> GRAN_SHIFT);
        push_cmd.in_pool = ({13'd0, addr_reg} >> GRAN_SHIFT) < 32'(POOL_GRANS);
        case (act_reg)
            ACT_CLEAR: push_cmd.op = OP_CLEAR;
            ACT_ALLOC, ACT_FREE:
            begin
                if (size_reg == 24'd0) begin
                    push_cmd.status = ST_ZERO;
                end else if (!found) begin
                    push_cmd.status = ST_LARGE;
                end else begin
                    push_cmd.cls = 6'(cls);
                    push_cmd.op = (act_reg == ACT_ALLOC) ? OP_ALLOC : OP_FREE;
                end
            end
            default: push_cmd.op = OP_NOP;
        endcase
    end

    assign push = hold_reg && !q_full;

    always_comb
    begin
        hold_next = hold_reg;
        if (push)
            hold_next = 1'b0;
        if (start && !hold_reg)
            hold_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_reg <= 1'b0;
        else
            hold_reg <= hold_next;
    end

    always_ff @(posedge clk)
    begin
        if (start && !hold_reg) begin
            act_reg  <= action;
            size_reg <= request_size;
            addr_reg <= block_address;
        end
    end
endmodule

// File: rtl/core/scba_queue.sv
module scba_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  scba_pkg::cmd_t  push_cmd,
    input  logic            pop,
    output logic            full,
    output logic            not_empty,
    output scba_pkg::cmd_t  head_cmd
);
    import scba_pkg::*;

    localparam int PW = $clog2(FIFO_DEPTH);

    cmd_t mem_reg [FIFO_DEPTH];
    logic [PW-1:0] wp_reg, rp_reg;
    logic [PW:0]   cnt_reg;

    assign full = cnt_reg == (PW+1)'(FIFO_DEPTH);
    assign not_empty = cnt_reg != '0;
    assign head_cmd = mem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (push)
                wp_reg <= wp_reg + 1'b1;
            if (pop)
                rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (PW+1)'(push) - (PW+1)'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= push_cmd;
    end
endmodule

// File: rtl/core/scba_back.sv
module scba_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic [3:0]      cfg_data,
    input  logic            q_valid,
    input  scba_pkg::cmd_t  q_cmd,
    output logic            q_pop,
    output logic            done,
    output logic [18:0]     result_address,
    output logic [1:0]      status,
    output logic [5:0]      size_class
);
    import scba_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_HEAD  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_CARVE = 3'd3;

    logic [2:0]  state_reg, state_next;
    logic [3:0]  limit_reg;
    logic [NCW-1:0] used_reg;
    logic [NUM_CLASSES-1:0] hv_reg;
    logic [GW-1:0] hg_mem [NUM_CLASSES];
    logic [GW-1:0] head_rd_reg;
    logic [GW:0]   link_mem [POOL_GRANS];
    logic [GW:0]   link_rd_reg;
    cmd_t          cur_reg;
    logic [GW-1:0] pos_reg;
    logic [GW-1:0] end_reg;
    logic [15:0]   step_reg;
    logic          lw_en;
    logic [GW-1:0] lw_addr;
    logic [GW:0]   lw_data;
    logic          hw_en;
    logic [5:0]    hw_addr;
    logic [GW-1:0] hw_data;
    logic [GW:0]   nxt;
    logic [GW-1:0] base;
    logic [15:0]   units;
    logic [NCW-1:0] lim;
    logic          cur_hv;

    assign q_pop = (state_reg == S_IDLE) && q_valid;
    assign units = class_units(cur_reg.cls);
    assign cur_hv = hv_reg[cur_reg.cls];
    assign base = GW'(used_reg) << CGW;
    assign lim = ({1'b0, limit_reg} < 5'(NUM_CHUNKS)) ? NCW'(limit_reg) : NCW'(NUM_CHUNKS);
    assign nxt = {1'b0, pos_reg} + (GW+1)'(step_reg);

    always_comb
    begin
        state_next = state_reg;
        lw_en = 1'b0;
        lw_addr = cur_reg.gran;
        lw_data = '0;
        hw_en = 1'b0;
        hw_addr = cur_reg.cls;
        hw_data = cur_reg.gran;
        case (state_reg)
            S_IDLE:
            begin
                if (q_pop)
                    state_next = S_HEAD;
            end
            S_HEAD:
            begin
                // The list head was read from the head table on the previous edge.
                if (cur_reg.op == OP_FREE && cur_reg.in_pool) begin
                    lw_en = 1'b1;
                    lw_data = cur_hv ? {1'b0, head_rd_reg} + 1'b1 : '0;
                    hw_en = 1'b1;
                end
                if (cur_reg.op == OP_ALLOC && cur_hv) begin
                    state_next = S_READ;
                end else if (cur_reg.op == OP_ALLOC && used_reg < lim) begin
                    hw_en = 1'b1;
                    hw_data = base + GW'(units);
                    state_next = S_CARVE;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_READ:
            begin
                state_next = S_IDLE;
                if (link_rd_reg != '0) begin
                    hw_en = 1'b1;
                    hw_data = GW'(link_rd_reg - 1'b1);
                end
            end
            S_CARVE:
            begin
                // Walk the fresh chunk one block a cycle, linking each to the next.
                // end_reg holds the highest start at which a block still fits in the chunk.
                lw_en = 1'b1;
                lw_addr = pos_reg;
                lw_data = (nxt > {1'b0, end_reg}) ? '0 : nxt + 1'b1;
                if (nxt > {1'b0, end_reg})
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (lw_en)
            link_mem[lw_addr] <= lw_data;
        link_rd_reg <= link_mem[head_rd_reg];
        if (hw_en)
            hg_mem[hw_addr] <= hw_data;
        if (q_pop) begin
            head_rd_reg <= hg_mem[q_cmd.cls];
            cur_reg <= q_cmd;
        end
        if (state_reg == S_HEAD) begin
            pos_reg <= base;
            end_reg <= base + GW'(CHUNK_GRANS) - GW'(units);
            step_reg <= units;
        end else if (state_reg == S_CARVE) begin
            pos_reg <= GW'(nxt);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
            limit_reg <= 4'd8;
            used_reg <= '0;
            hv_reg <= '0;
            done <= 1'b0;
            result_address <= '0;
            status <= '0;
            size_class <= '0;
        end else begin
            state_reg <= state_next;
            done <= 1'b0;
            if (cfg_we)
                limit_reg <= cfg_data;
            case (state_reg)
                S_HEAD:
                begin
                    result_address <= '0;
                    status <= cur_reg.status;
                    size_class <= cur_reg.cls;
                    done <= 1'b1;
                    case (cur_reg.op)
                        OP_CLEAR:
                        begin
                            hv_reg <= '0;
                            used_reg <= '0;
                        end
                        OP_FREE:
                        begin
                            if (cur_reg.in_pool)
                                hv_reg[cur_reg.cls] <= 1'b1;
                        end
                        OP_ALLOC:
                        begin
                            if (cur_hv) begin
                                done <= 1'b0;
                            end else if (used_reg >= lim) begin
                                status <= ST_OUT;
                            end else begin
                                result_address <= 19'({base, GRAN_SHIFT'(0)});
                                used_reg <= used_reg + 1'b1;
                                hv_reg[cur_reg.cls] <= units < 16'(CHUNK_GRANS / 2 + 1);
                            end
                        end
                        default: ;
                    endcase
                end
                S_READ:
                begin
                    done <= 1'b1;
                    result_address <= 19'({head_rd_reg, GRAN_SHIFT'(0)});
                    status <= ST_DONE;
                    size_class <= cur_reg.cls;
                    if (link_rd_reg == '0)
                        hv_reg[cur_reg.cls] <= 1'b0;
                end
                default: ;
            endcase
        end
    end
endmodule

// File: rtl/core/scba_checker.sv
module scba_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [18:0] result_address,
    input logic [1:0]  status,
    input logic [5:0]  size_class
);
    import scba_pkg::*;

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy) else $error("accepted transfer did not raise busy");
    a_status_addr: assert property (@(posedge clk) disable iff (!rst_n)
        done && status != ST_DONE |-> result_address == '0)
        else $error("address given with failing status");
    a_cls_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> size_class < 6'(NUM_CLASSES)) else $error("class out of range");
    a_zero_cls: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status == ST_ZERO || status == ST_LARGE) |-> size_class == '0)
        else $error("class given for rejected size");
endmodule

bind size_class_block_allocator_top scba_checker u_scba_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
    .result_address(result_address), .status(status), .size_class(size_class)
);
